@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL of the flight timer sequencer.
// Depends on nothing; assertions are clocked by clk_i and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

@@ rtl/fts_pkg.sv @@
// Package for the flight timer sequencer: modes, state structs and constant tables.
// Depends on nothing.
package fts_pkg;

  typedef enum logic [4:0] {
    M_SETUP, M_TMAX, M_REL1, M_TMIN, M_REL2, M_SW1, M_EW1, M_EDM, M_SW2,
    M_EW2, M_EDD, M_WSTART, M_WREL, M_RUN, M_FREE, M_TRIG, M_WRESTART
  } mode_e;

  localparam logic [7:0] CmpMax     = 8'd129;
  localparam logic [7:0] CmpMin     = 8'd64;
  localparam logic [7:0] EscIdle    = 8'd85;
  localparam logic [2:0] MotorLast  = 3'd5;
  localparam logic [3:0] DtLast     = 4'd8;
  localparam int         StepTicks  = 20;

  localparam logic [2:0] CfgMotor   = 3'd0;
  localparam logic [2:0] CfgDt      = 3'd1;
  localparam logic [2:0] CfgDebnc   = 3'd2;
  localparam logic [2:0] CfgEdit    = 3'd3;
  localparam logic [2:0] CfgServo   = 3'd4;
  localparam logic [2:0] CfgEsc     = 3'd5;

  typedef struct packed {
    mode_e       mode;
    logic [7:0]  quiet;
    logic [15:0] deadline;
    logic        brs;
    logic [2:0]  motor;
    logic [3:0]  dt;
    logic [7:0]  servo;
    logic [7:0]  esc;
    logic        led;
    logic        servo_en;
    logic        esc_en;
  } st_t;

  // frame counter view after this word's increment
  typedef struct packed {
    logic [15:0] fc;
    logic [3:0]  step20;
    logic        sec_odd;
    logic [3:0]  fast_ph;
  } tb_t;

  typedef struct packed {
    logic [2:0]  init_motor;
    logic [3:0]  init_dt;
    logic [7:0]  debounce;
    logic [15:0] edit_ticks;
    logic [17:0] servo_off_ticks;
    logic [17:0] esc_off_ticks;
  } cfg_t;

  function automatic logic [7:0] motor_secs(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0: r = 8'd2;
      3'd1: r = 8'd4;
      3'd2: r = 8'd5;
      3'd3: r = 8'd7;
      3'd4: r = 8'd10;
      3'd5: r = 8'd13;
      3'd6: r = 8'd15;
      default: r = 8'd2;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] dt_secs(input logic [3:0] idx);
    logic [8:0] r;
    case (idx)
      4'd0, 4'd9:  r = 9'd0;
      4'd1, 4'd10: r = 9'd5;
      4'd2, 4'd11: r = 9'd30;
      4'd3, 4'd12: r = 9'd60;
      4'd4, 4'd13: r = 9'd90;
      4'd5, 4'd14: r = 9'd120;
      4'd6, 4'd15: r = 9'd180;
      4'd7:        r = 9'd240;
      default:     r = 9'd300;
    endcase
    return r;
  endfunction

  // servo position for a motor choice: 64 + 65*idx/5
  function automatic logic [7:0] motor_cmp(input logic [3:0] idx);
    logic [11:0] v;
    v = 12'd64 + 12'd13 * {8'd0, idx};
    return v[7:0];
  endfunction

  // servo position for a dethermalizer choice: 64 + 65*idx/8
  function automatic logic [7:0] dt_cmp(input logic [3:0] idx);
    logic [11:0] v;
    v = 12'd65 * {8'd0, idx};
    v = 12'd64 + (v >> 3);
    return v[7:0];
  endfunction

endpackage

@@ rtl/fts_timebase.sv @@
// Frame counter with running quotients for the display step and LED flash phases.
// Depends on fts_pkg.
module fts_timebase #(
  parameter int TicksPerSec = 49
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic         clear_i,
  output fts_pkg::tb_t tb_o
);
  import fts_pkg::*;

  localparam int FastDiv = TicksPerSec / 5;
  localparam int SecW    = $clog2(TicksPerSec);
  localparam int FastW   = $clog2(FastDiv);
  localparam logic [SecW-1:0]  SecLast  = SecW'(TicksPerSec - 1);
  localparam logic [FastW-1:0] FastLast = FastW'(FastDiv - 1);

  logic [15:0]      fc_q, fc_d;
  logic [4:0]       r20_q, r20_d;
  logic [3:0]       q20_q, q20_d;
  logic [SecW-1:0]  rs_q, rs_d;
  logic             qs_q, qs_d;
  logic [FastW-1:0] rf_q, rf_d;
  logic [3:0]       qf_q, qf_d;
  logic             adv;

  always_comb begin
    adv   = (fc_q != 16'hFFFF);
    fc_d  = fc_q;
    r20_d = r20_q;
    q20_d = q20_q;
    rs_d  = rs_q;
    qs_d  = qs_q;
    rf_d  = rf_q;
    qf_d  = qf_q;
    if (adv) begin
      fc_d = fc_q + 16'd1;
      if (r20_q == 5'(StepTicks - 1)) begin
        r20_d = '0;
        if (q20_q != 4'hF) q20_d = q20_q + 4'd1;
      end else begin
        r20_d = r20_q + 5'd1;
      end
      if (rs_q == SecLast) begin
        rs_d = '0;
        qs_d = ~qs_q;
      end else begin
        rs_d = rs_q + SecW'(1);
      end
      if (rf_q == FastLast) begin
        rf_d = '0;
        qf_d = (qf_q == 4'd9) ? 4'd0 : qf_q + 4'd1;
      end else begin
        rf_d = rf_q + FastW'(1);
      end
    end
  end

  assign tb_o = '{fc: fc_d, step20: q20_d, sec_odd: qs_d, fast_ph: qf_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q  <= '0;
      r20_q <= '0;
      q20_q <= '0;
      rs_q  <= '0;
      qs_q  <= 1'b0;
      rf_q  <= '0;
      qf_q  <= '0;
    end else if (step_i) begin
      if (clear_i) begin
        fc_q  <= '0;
        r20_q <= '0;
        q20_q <= '0;
        rs_q  <= '0;
        qs_q  <= 1'b0;
        rf_q  <= '0;
        qf_q  <= '0;
      end else begin
        fc_q  <= fc_d;
        r20_q <= r20_d;
        q20_q <= q20_d;
        rs_q  <= rs_d;
        qs_q  <= qs_d;
        rf_q  <= rf_d;
        qf_q  <= qf_d;
      end
    end
  end

endmodule

@@ rtl/fts_step.sv @@
// Next-state logic of the 17-mode sequencer for one tick.
// Depends on fts_pkg.
module fts_step #(
  parameter int TicksPerSec = 49
) (
  input  fts_pkg::st_t  st_i,
  input  fts_pkg::tb_t  tb_i,
  input  fts_pkg::cfg_t cfg_i,
  input  logic          down_i,
  input  logic          rc_i,
  input  logic          changed_i,
  output fts_pkg::st_t  st_o,
  output logic          clear_o,
  output logic          save_o
);
  import fts_pkg::*;

  st_t         s;
  logic        sample;
  logic        hit;
  logic        clr;
  logic        sv;
  logic [16:0] dl_sum;
  logic [15:0] dl_new;
  logic [16:0] run_lim;
  logic [16:0] free_lim;
  logic [16:0] fc_run;
  logic        exp_run;
  logic        srv_off;
  logic        esc_off;
  logic        fast_led;
  logic        dbl_led;
  logic        tri_led;
  logic [3:0]  ph;

  always_comb begin
    s   = st_i;
    clr = 1'b0;
    sv  = 1'b0;

    dl_sum   = {1'b0, tb_i.fc} + {1'b0, cfg_i.edit_ticks};
    dl_new   = dl_sum[16] ? 16'hFFFF : dl_sum[15:0];
    run_lim  = 17'((32'(motor_secs(st_i.motor)) + 32'd1) * 32'(TicksPerSec));
    free_lim = 17'((32'(dt_secs(st_i.dt)) + 32'd1) * 32'(TicksPerSec));
    fc_run   = {1'b0, tb_i.fc} + 17'(CmpMax - CmpMin);
    exp_run  = fc_run >= run_lim;
    srv_off  = {2'b0, tb_i.fc} > cfg_i.servo_off_ticks;
    esc_off  = {2'b0, tb_i.fc} > cfg_i.esc_off_ticks;

    if (changed_i) s.quiet = '0;
    if (s.quiet != 8'hFF) s.quiet = s.quiet + 8'd1;
    sample = s.quiet > cfg_i.debounce;
    hit    = sample && down_i && s.brs;

    if (s.mode == M_SETUP) begin
      s.motor = (cfg_i.init_motor > MotorLast) ? MotorLast : cfg_i.init_motor;
      s.dt    = (cfg_i.init_dt > DtLast) ? DtLast : cfg_i.init_dt;
      s.mode  = down_i ? M_TMAX : M_SW1;
    end

    case (s.mode)
      M_TMAX: begin
        s.servo = (s.servo < CmpMax - 8'd2) ? s.servo + 8'd2 : CmpMax;
        s.esc   = s.servo;
        if (s.servo >= CmpMax) begin
          s.esc_en = 1'b1;
          s.mode   = M_REL1;
        end
      end
      M_REL1, M_REL2: begin
        if (sample) begin
          s.brs   = !down_i;
          s.quiet = '0;
        end
        if (hit) s.mode = (s.mode == M_REL1) ? M_TMIN : M_TMAX;
      end
      M_TMIN: begin
        s.servo = (s.servo > CmpMin + 8'd2) ? s.servo - 8'd2 : CmpMin;
        s.esc   = s.servo;
        if (s.servo <= CmpMin) s.mode = M_REL2;
      end
      M_SW1, M_SW2: begin
        s.servo = (s.servo < CmpMax - 8'd2) ? s.servo + 8'd2 : CmpMax;
        if (s.servo >= CmpMax) begin
          s.mode = (s.mode == M_SW1) ? M_EW1 : M_EW2;
          clr    = 1'b1;
        end
      end
      M_EW1, M_EW2: begin
        s.servo = (s.servo > CmpMin + 8'd2) ? s.servo - 8'd2 : CmpMin;
        if (s.servo <= CmpMin) begin
          s.mode     = (s.mode == M_EW1) ? M_EDM : M_EDD;
          clr        = 1'b1;
          s.deadline = cfg_i.edit_ticks;
        end
      end
      M_EDM: begin
        if (tb_i.step20 <= {1'b0, s.motor}) begin
          s.servo    = motor_cmp(tb_i.step20);
          s.deadline = dl_new;
        end else begin
          s.servo = motor_cmp({1'b0, s.motor});
        end
        if (sample) begin
          s.brs   = !down_i;
          s.quiet = '0;
        end
        if (hit) begin
          s.motor    = (s.motor < MotorLast) ? s.motor + 3'd1 : 3'd0;
          s.deadline = dl_new;
        end
        if (tb_i.fc > s.deadline) begin
          s.mode = M_SW2;
          clr    = 1'b1;
        end
      end
      M_EDD: begin
        if (tb_i.step20 <= s.dt) begin
          s.servo    = dt_cmp(tb_i.step20);
          s.deadline = dl_new;
        end else begin
          s.servo = dt_cmp(s.dt);
        end
        if (sample) begin
          s.brs   = !down_i;
          s.quiet = '0;
        end
        if (hit) begin
          s.dt       = (s.dt < DtLast) ? s.dt + 4'd1 : 4'd0;
          s.deadline = dl_new;
        end
        if (tb_i.fc > s.deadline) begin
          s.esc_en = 1'b1;
          s.mode   = M_WSTART;
          clr      = 1'b1;
          sv       = 1'b1;
        end
      end
      M_WSTART: begin
        if (srv_off) s.servo_en = 1'b0;
        if (esc_off) s.esc_en = 1'b0;
        s.servo = (s.servo > CmpMin + 8'd2) ? s.servo - 8'd2 : CmpMin;
        if (s.servo <= CmpMin) begin
          if (sample) begin
            s.brs   = !down_i;
            s.quiet = '0;
          end
          if (hit) begin
            s.mode     = M_WREL;
            s.servo_en = 1'b1;
            s.esc_en   = 1'b1;
          end
          s.led = !tb_i.sec_odd;
        end
      end
      M_WREL: begin
        s.esc = (s.esc < EscIdle) ? s.esc + 8'd1 : EscIdle;
        if (sample) begin
          if (!down_i && !s.brs) begin
            s.mode = M_RUN;
            clr    = 1'b1;
          end
          s.brs   = !down_i;
          s.quiet = '0;
        end
      end
      M_RUN: begin
        if (exp_run) begin
          s.esc = (s.esc > CmpMin) ? s.esc - 8'd1 : CmpMin;
          if (s.esc <= CmpMin) begin
            s.led  = 1'b0;
            s.mode = M_FREE;
          end else begin
            s.led = 1'b1;
          end
        end else begin
          if (s.esc >= CmpMax) begin
            s.led = 1'b0;
          end else begin
            s.led = 1'b1;
            s.esc = s.esc + 8'd1;
          end
          if (rc_i) begin
            s.mode = M_TRIG;
            clr    = 1'b1;
          end else begin
            if (sample) begin
              s.brs   = !down_i;
              s.quiet = '0;
            end
            if (hit) begin
              s.mode = M_WSTART;
              clr    = 1'b1;
              s.esc  = CmpMin;
            end
          end
        end
      end
      M_FREE: begin
        if (rc_i || ({1'b0, tb_i.fc} >= free_lim)) begin
          s.mode = M_TRIG;
          clr    = 1'b1;
        end
      end
      M_TRIG: begin
        s.esc   = CmpMin;
        s.servo = (s.servo < CmpMax - 8'd2) ? s.servo + 8'd2 : CmpMax;
        if (s.servo >= CmpMax) s.mode = M_WRESTART;
      end
      M_WRESTART: begin
        if (srv_off) s.servo_en = 1'b0;
        if (esc_off) s.esc_en = 1'b0;
        if (sample) begin
          s.brs   = !down_i;
          s.quiet = '0;
        end
        if (hit) begin
          s.mode     = M_WSTART;
          clr        = 1'b1;
          s.servo_en = 1'b1;
          s.esc_en   = 1'b1;
        end
      end
      default: ;
    endcase

    // flash patterns read the phase after any counter restart
    ph       = clr ? 4'd0 : tb_i.fast_ph;
    fast_led = !ph[0];
    dbl_led  = (ph == 4'd0) || (ph == 4'd3);
    tri_led  = (ph == 4'd0) || (ph == 4'd2) || (ph == 4'd4);
    case (st_i.mode == M_SETUP ? M_SETUP : st_i.mode)
      M_EDM:                          s.led = dbl_led;
      M_EDD:                          s.led = tri_led;
      M_WREL, M_WRESTART:             s.led = fast_led;
      default: ;
    endcase
  end

  assign st_o    = s;
  assign clear_o = clr;
  assign save_o  = sv;

endmodule

@@ rtl/flight_timer_sequencer_core.sv @@
// Top level of the flight timer sequencer: handshake, config registers, state.
// Depends on fts_pkg, fts_timebase, fts_step and assert_macros.svh.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o) carries one tick word per frame:
//    button level, radio dethermalizer pin and a pin-change flag.
//  - Output channel (out_valid_o / out_stall_i) returns one result word per
//    tick: servo and ESC widths, enables, LED, mode, save strobe, choices.
//  - Flow: a word accepted into the input register is stepped once the
//    result slot is free or draining; its result is shown from that step on.
//  - Throughput: one word per cycle while unstalled; the step is a single
//    pass of compare/add logic between input and state/result registers.
//  - Stall: while the receiver stalls, the result word holds; one more input
//    word is taken into the input register, then in_stall_o rises.
//  - Reset: state returns to power-on (setup mode); the first tick loads the
//    saved choices. Config registers return to their defaults.
//  - Config: write with cfg_we_i, cfg_index_i, cfg_wdata_i while idle.
`include "assert_macros.svh"
module flight_timer_sequencer_core #(
  parameter int TicksPerSec = 49
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       button_down_i,
  input  logic       rc_dt_active_i,
  input  logic       pin_changed_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] servo_width_o,
  output logic [7:0] esc_width_o,
  output logic       servo_enable_o,
  output logic       esc_enable_o,
  output logic       led_on_o,
  output logic [4:0] mode_o,
  output logic       save_strobe_o,
  output logic [2:0] motor_choice_o,
  output logic [3:0] dethermal_choice_o,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_index_i,
  input  logic [9:0] cfg_wdata_i
);
  import fts_pkg::*;

  cfg_t cfg_q;
  st_t  st_q, st_d;
  tb_t  tb;
  logic in_valid_q;
  logic down_q, rc_q, chg_q;
  logic out_valid_q;
  logic save_q, save_d;
  logic can_step, step_en, in_acc, clr;

  // Config: store power-down and edit times already scaled to ticks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.init_motor      <= 3'd0;
      cfg_q.init_dt         <= 4'd0;
      cfg_q.debounce        <= 8'd3;
      cfg_q.edit_ticks      <= 16'(3 * TicksPerSec);
      cfg_q.servo_off_ticks <= 18'(30 * TicksPerSec);
      cfg_q.esc_off_ticks   <= 18'(300 * TicksPerSec);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgMotor: cfg_q.init_motor <= cfg_wdata_i[2:0];
        CfgDt:    cfg_q.init_dt    <= cfg_wdata_i[3:0];
        CfgDebnc: cfg_q.debounce   <= cfg_wdata_i[7:0];
        CfgEdit:  cfg_q.edit_ticks <= 16'({10'd0, cfg_wdata_i[5:0]} * 16'(TicksPerSec));
        CfgServo: cfg_q.servo_off_ticks <= 18'({8'd0, cfg_wdata_i} * 18'(TicksPerSec));
        CfgEsc:   cfg_q.esc_off_ticks   <= 18'({8'd0, cfg_wdata_i} * 18'(TicksPerSec));
        default: ;
      endcase
    end
  end

  // Step when an input word waits and the result slot is free or draining.
  assign can_step   = !out_valid_q || !out_stall_i;
  assign step_en    = in_valid_q && can_step;
  assign in_stall_o = in_valid_q && !can_step;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_acc) begin
      in_valid_q <= 1'b1;
    end else if (step_en) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      down_q <= button_down_i;
      rc_q   <= rc_dt_active_i;
      chg_q  <= pin_changed_i;
    end
  end

  fts_timebase #(.TicksPerSec(TicksPerSec)) u_timebase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step_en),
    .clear_i (clr),
    .tb_o    (tb)
  );

  fts_step #(.TicksPerSec(TicksPerSec)) u_step (
    .st_i      (st_q),
    .tb_i      (tb),
    .cfg_i     (cfg_q),
    .down_i    (down_q),
    .rc_i      (rc_q),
    .changed_i (chg_q),
    .st_o      (st_d),
    .clear_o   (clr),
    .save_o    (save_d)
  );

  // State doubles as the result register: it only advances when the
  // previous result has been taken or is taken at this edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{mode: M_SETUP, quiet: 8'd0, deadline: 16'd0, brs: 1'b0,
                motor: 3'd0, dt: 4'd0, servo: CmpMin, esc: CmpMin,
                led: 1'b0, servo_en: 1'b1, esc_en: 1'b0};
      save_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (step_en) begin
      st_q        <= st_d;
      save_q      <= save_d;
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign servo_width_o      = st_q.servo;
  assign esc_width_o        = st_q.esc;
  assign servo_enable_o     = st_q.servo_en;
  assign esc_enable_o       = st_q.esc_en;
  assign led_on_o           = st_q.led;
  assign mode_o             = st_q.mode;
  assign save_strobe_o      = save_q;
  assign motor_choice_o     = st_q.motor;
  assign dethermal_choice_o = st_q.dt;

  `ASSERT_IMPL(a_save_mode, out_valid_o && save_strobe_o, st_q.mode == M_WSTART,
               "save strobe outside wait-start mode")
  `ASSERT_IMPL(a_servo_rng, out_valid_o, servo_width_o >= CmpMin && servo_width_o <= CmpMax,
               "servo width out of range")
  `ASSERT_IMPL(a_stall_why, in_stall_o, out_valid_o && out_stall_i,
               "input stalled without a held result")

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for flight_timer_sequencer_core: random ticks drive the
// sequencer, and a scoreboard with its own mode model checks every result word.
// Depends on fts_pkg and the RTL of the block.

import fts_pkg::*;

typedef struct {
  logic [7:0] servo;
  logic [7:0] esc;
  logic       servo_en;
  logic       esc_en;
  logic       led;
  logic [4:0] mode;
  logic       save;
  logic [2:0] motor;
  logic [3:0] dt;
} frame_out_t;

class flight_scoreboard;
  frame_out_t  pending[$];
  int          errors;
  int          checked;
  // configuration copy
  int unsigned init_motor, init_dt, debounce, edit_s, servo_off_s, esc_off_s;
  // sequencer state copy
  mode_e       mode;
  int unsigned fc, quiet, deadline, released, motor, dt;
  int unsigned servo, esc, led, servo_en, esc_en;

  function new();
    init_motor = 0; init_dt = 0; debounce = 3; edit_s = 3;
    servo_off_s = 30; esc_off_s = 300;
    mode = M_SETUP; fc = 0; quiet = 0; deadline = 0; released = 0;
    motor = 0; dt = 0; servo = 64; esc = 64; led = 0; servo_en = 1; esc_en = 0;
    errors = 0; checked = 0;
  endfunction

  function void write_cfg(logic [2:0] idx, logic [9:0] val);
    case (idx)
      CfgMotor: init_motor = val[2:0];
      CfgDt:    init_dt = val[3:0];
      CfgDebnc: debounce = val[7:0];
      CfgEdit:  edit_s = val[5:0];
      CfgServo: servo_off_s = val;
      CfgEsc:   esc_off_s = val;
      default: ;
    endcase
  endfunction

  function int unsigned sat16(int unsigned v);
    return v > 65535 ? 65535 : v;
  endfunction

  function void servo_up();
    servo = (servo + 2 < 129) ? servo + 2 : 129;
  endfunction

  function void servo_down();
    servo = (servo > 66) ? servo - 2 : 64;
  endfunction

  function void wipe_up(mode_e nxt);
    servo_up();
    if (servo >= 129) begin
      mode = nxt; fc = 0;
    end
  endfunction

  function void wipe_down(mode_e nxt);
    servo_down();
    if (servo <= 64) begin
      mode = nxt; fc = 0; deadline = sat16(edit_s * 49);
    end
  endfunction

  function void show(int unsigned idx, int unsigned last);
    int unsigned stp;
    stp = fc / 20;
    if (stp <= idx) begin
      servo = 64 + 65 * stp / last;
      deadline = sat16(fc + edit_s * 49);
    end else begin
      servo = 64 + 65 * idx / last;
    end
  endfunction

  // debounced press: true on a press that follows a seen release
  function bit pressed(bit down);
    bit hit;
    hit = 0;
    if (quiet > debounce) begin
      if (down) begin
        if (released != 0) begin
          hit = 1; released = 0;
        end
      end else begin
        released = 1;
      end
      quiet = 0;
    end
    return hit;
  endfunction

  function void power_down();
    if (fc > servo_off_s * 49) servo_en = 0;
    if (fc > esc_off_s * 49) esc_en = 0;
  endfunction

  function int unsigned motor_time(int unsigned i);
    int unsigned t[7] = '{2, 4, 5, 7, 10, 13, 15};
    return t[i % 7];
  endfunction

  function int unsigned dt_time(int unsigned i);
    int unsigned t[9] = '{0, 5, 30, 60, 90, 120, 180, 240, 300};
    return t[i % 9];
  endfunction

  // advance the model by one tick and queue the resulting word
  function void note_tick(bit down, bit rc, bit changed);
    frame_out_t  r;
    int unsigned ph;
    bit          save;
    save = 0;
    if (fc < 65535) fc++;
    if (changed) quiet = 0;
    if (quiet < 255) quiet++;
    if (mode == M_SETUP) begin
      motor = init_motor > 5 ? 5 : init_motor;
      dt = init_dt > 8 ? 8 : init_dt;
      mode = down ? M_TMAX : M_SW1;
    end
    ph = fc / 9;
    case (mode)
      M_TMAX: begin
        servo_up(); esc = servo;
        if (servo >= 129) begin
          esc_en = 1; mode = M_REL1;
        end
      end
      M_REL1: if (pressed(down)) mode = M_TMIN;
      M_TMIN: begin
        servo_down(); esc = servo;
        if (servo <= 64) mode = M_REL2;
      end
      M_REL2: if (pressed(down)) mode = M_TMAX;
      M_SW1: wipe_up(M_EW1);
      M_EW1: wipe_down(M_EDM);
      M_EDM: begin
        show(motor, 5);
        if (pressed(down)) begin
          motor = motor < 5 ? motor + 1 : 0;
          deadline = sat16(fc + edit_s * 49);
        end
        if (fc > deadline) begin
          mode = M_SW2; fc = 0;
        end
        ph = fc / 9;
        led = (ph % 10 == 0) || (ph % 10 == 3);
      end
      M_SW2: wipe_up(M_EW2);
      M_EW2: wipe_down(M_EDD);
      M_EDD: begin
        show(dt, 8);
        if (pressed(down)) begin
          dt = dt < 8 ? dt + 1 : 0;
          deadline = sat16(fc + edit_s * 49);
        end
        if (fc > deadline) begin
          esc_en = 1; mode = M_WSTART; fc = 0; save = 1;
        end
        ph = fc / 9;
        led = (ph % 10 == 0) || (ph % 10 == 2) || (ph % 10 == 4);
      end
      M_WSTART: begin
        power_down();
        servo_down();
        if (servo <= 64) begin
          if (pressed(down)) begin
            mode = M_WREL; servo_en = 1; esc_en = 1;
          end
          led = ((fc / 49) % 2) == 0;
        end
      end
      M_WREL: begin
        esc = esc < 85 ? esc + 1 : 85;
        if (quiet > debounce) begin
          if (!down) begin
            if (released == 0) begin
              mode = M_RUN; fc = 0; released = 1;
            end
          end else begin
            released = 0;
          end
          quiet = 0;
        end
        led = ((fc / 9) % 2) == 0;
      end
      M_RUN: begin
        if ((fc + 65) / 49 > motor_time(motor)) begin
          esc = esc > 64 ? esc - 1 : 64;
          if (esc <= 64) begin
            led = 0; mode = M_FREE;
          end else begin
            led = 1;
          end
        end else begin
          if (esc >= 129) begin
            led = 0;
          end else begin
            led = 1; esc++;
          end
          if (rc) begin
            mode = M_TRIG; fc = 0;
          end else if (pressed(down)) begin
            mode = M_WSTART; fc = 0; esc = 64;
          end
        end
      end
      M_FREE: begin
        if (rc || fc / 49 > dt_time(dt)) begin
          mode = M_TRIG; fc = 0;
        end
      end
      M_TRIG: begin
        esc = 64;
        servo_up();
        if (servo >= 129) mode = M_WRESTART;
      end
      M_WRESTART: begin
        power_down();
        if (pressed(down)) begin
          mode = M_WSTART; fc = 0; servo_en = 1; esc_en = 1;
        end
        led = ((fc / 9) % 2) == 0;
      end
      default: ;
    endcase
    r.servo = servo[7:0]; r.esc = esc[7:0]; r.servo_en = servo_en[0];
    r.esc_en = esc_en[0]; r.led = led[0]; r.mode = mode; r.save = save;
    r.motor = motor[2:0]; r.dt = dt[3:0];
    pending.push_back(r);
  endfunction

  function void cmp(string name, int unsigned e, int unsigned a);
    if (e != a) begin
      $error("%s: expected %0d, actual %0d", name, e, a);
      errors++;
    end
  endfunction

  function void check_word(frame_out_t a);
    frame_out_t e;
    if (pending.size() == 0) begin
      $error("result word with no tick waiting");
      errors++;
      return;
    end
    e = pending.pop_front();
    checked++;
    cmp("servo_width", e.servo, a.servo);
    cmp("esc_width", e.esc, a.esc);
    cmp("servo_enable", e.servo_en, a.servo_en);
    cmp("esc_enable", e.esc_en, a.esc_en);
    cmp("led_on", e.led, a.led);
    cmp("mode", e.mode, a.mode);
    cmp("save_strobe", e.save, a.save);
    cmp("motor_choice", e.motor, a.motor);
    cmp("dethermal_choice", e.dt, a.dt);
  endfunction
endclass

module tb;
  logic       clk_i = 0;
  logic       rst_ni = 0;
  logic       in_valid_i = 0;
  logic       in_stall_o;
  logic       button_down_i = 0;
  logic       rc_dt_active_i = 0;
  logic       pin_changed_i = 0;
  logic       out_valid_o;
  logic       out_stall_i = 1;
  logic [7:0] servo_width_o;
  logic [7:0] esc_width_o;
  logic       servo_enable_o;
  logic       esc_enable_o;
  logic       led_on_o;
  logic [4:0] mode_o;
  logic       save_strobe_o;
  logic [2:0] motor_choice_o;
  logic [3:0] dethermal_choice_o;
  logic       cfg_we_i = 0;
  logic [2:0] cfg_index_i = '0;
  logic [9:0] cfg_wdata_i = '0;

  flight_scoreboard tick_model = new();
  int  ticks_sent = 0;
  int  gap_free = 0;     // when set, the sender drives back to back
  int  stall_free = 0;   // when set, the receiver never stalls
  bit  btn_level = 0;
  int  btn_hold = 5;

  flight_timer_sequencer_core dut (.*);

  always #4 clk_i = ~clk_i;

  // Write one config register and mirror it in the model; block is idle here.
  task automatic cfg_write(logic [2:0] idx, logic [9:0] val);
    cfg_we_i <= 1; cfg_index_i <= idx; cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    tick_model.write_cfg(idx, val);
  endtask

  task automatic cfg_all(int unsigned db, int unsigned ed, int unsigned so, int unsigned eo);
    cfg_write(CfgDebnc, 10'(db));
    cfg_write(CfgEdit, 10'(ed));
    cfg_write(CfgServo, 10'(so));
    cfg_write(CfgEsc, 10'(eo));
  endtask

  // Offer one tick word after a random gap; hold it until accepted.
  task automatic send_tick(bit down, bit rc, bit changed);
    int gap;
    gap = gap_free ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    button_down_i <= down; rc_dt_active_i <= rc; pin_changed_i <= changed;
    do @(posedge clk_i); while (in_stall_o);
    tick_model.note_tick(down, rc, changed);
    ticks_sent++;
  endtask

  // Button held in runs of random length so debounce lets presses through;
  // a few words carry noise on the change flag or fully random bits.
  task automatic send_random_tick();
    bit changed;
    bit rc;
    changed = 0;
    if (btn_hold == 0) begin
      btn_level = ~btn_level; changed = 1; btn_hold = $urandom_range(1, 30);
    end else begin
      btn_hold--;
      if ($urandom_range(0, 15) == 0) changed = 1;
    end
    rc = ($urandom_range(0, 149) == 0);
    if ($urandom_range(0, 19) == 0)
      send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    else
      send_tick(btn_level, rc, changed);
  endtask

  // Drain: drop valid, then wait until every expected word has arrived.
  task automatic drain();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (tick_model.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(int n);
    repeat (n) begin
      if ($urandom_range(0, 99) == 0) gap_free = !gap_free;
      send_random_tick();
    end
    gap_free = 0;
  endtask

  // Receiver: random stall before each word, one long hold-off mid run.
  initial begin
    int w;
    int got;
    got = 0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 99) == 0) stall_free = !stall_free;
      w = stall_free ? 0 : $urandom_range(0, 19);
      if (got == 700) w = 300;
      if (w > 0) begin
        out_stall_i <= 1;
        repeat (w) @(posedge clk_i);
      end
      out_stall_i <= 0;
      do @(posedge clk_i); while (!out_valid_o);
      got++;
    end
  end

  // Monitor: check each accepted result word.
  always @(posedge clk_i) begin
    frame_out_t a;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      a.servo = servo_width_o; a.esc = esc_width_o; a.servo_en = servo_enable_o;
      a.esc_en = esc_enable_o; a.led = led_on_o; a.mode = mode_o;
      a.save = save_strobe_o; a.motor = motor_choice_o; a.dt = dethermal_choice_o;
      tick_model.check_word(a);
    end
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Initial choices take effect on the power-on tick only; values clamp.
    cfg_write(CfgMotor, 10'h3FF);
    cfg_write(CfgDt, 10'd1);
    cfg_all(3, 3, 30, 300);
    // Power-on tick with button released enters the wipe / edit sequence.
    send_tick(0, 0, 0);
    for (int i = 0; i < 8; i++) send_tick(i[0], i[1], i[2]);
    repeat (12) send_tick(0, 0, 0);
    run_phase(480);
    drain();
    // Shortest nonzero timeouts and fastest debounce.
    cfg_write(CfgMotor, 10'd2);
    cfg_write(CfgDt, 10'hF);
    cfg_all(0, 1, 1, 1);
    run_phase(300);
    drain();
    // Long edit and power-down times; debounce never samples the button.
    cfg_all(255, 60, 1000, 1000);
    run_phase(100);
    drain();
    // Zero timeouts.
    cfg_all(0, 0, 0, 0);
    run_phase(150);
    drain();
    // Random settings over the full width, but for a small debounce at first.
    cfg_write(CfgMotor, 10'($urandom_range(0, 7)));
    cfg_write(CfgDt, 10'($urandom_range(0, 15)));
    cfg_all($urandom_range(0, 7), $urandom_range(0, 63), $urandom_range(0, 1023),
            $urandom_range(0, 1023));
    run_phase(200);
    drain();
    cfg_all($urandom_range(0, 255), $urandom_range(0, 63), $urandom_range(0, 1023),
            $urandom_range(0, 1023));
    run_phase(100);
    drain();
    cfg_all(2, 3, 5, 5);
    run_phase(250);
    drain();
    $display("Sent %0d ticks over seven config settings; checked %0d result words.",
             ticks_sent, tick_model.checked);
    if (tick_model.errors == 0 && tick_model.pending.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
